[hdl/led_strip_bit_encoder_defines.svh]
// Assertion macros shared by the LED strip encoder RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef LED_STRIP_BIT_ENCODER_DEFINES_SVH
`define LED_STRIP_BIT_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

`define LSBE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("led strip encoder assertion failed");

`define LSBE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("led strip encoder assertion failed");

`else

`define LSBE_ASSERT(label, prop)

`define LSBE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/lsbe_pkg.sv]
`timescale 1ns / 1ps

package lsbe_pkg;

  localparam int unsigned LED_COUNT = 16;
  localparam int unsigned ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned BIT_W   = 5;

  localparam logic [BIT_W-1:0]  LAST_BIT = BIT_W'(COLOR_W - 1);
  localparam logic [ADDR_W-1:0] LED_LAST = ADDR_W'(LED_COUNT - 1);

  localparam logic [CODE_W-1:0] ZERO_CODE_RST = 8'hC0;
  localparam logic [CODE_W-1:0] ONE_CODE_RST  = 8'hF8;
  localparam logic [CODE_W-1:0] FRAME_PAD     = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE      = 3'd0,
    OP_WRITE_SEND = 3'd1,
    OP_FILL_SEND  = 3'd2,
    OP_SEND       = 3'd3,
    OP_PULL       = 3'd4
  } op_e;

  typedef enum logic {
    CFG_ZERO_CODE = 1'b0,
    CFG_ONE_CODE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] data;
  } pixel_wr_t;

endpackage

[hdl/lsbe_if.sv]
`timescale 1ns / 1ps

interface lsbe_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsbe_pkg::OP_W-1:0]    opcode;
  logic [lsbe_pkg::IDX_W-1:0]   pixel_idx;
  logic [lsbe_pkg::COLOR_W-1:0] pixel_color;

  modport source (output valid, output opcode, output pixel_idx, output pixel_color,
                  input ready);
  modport sink   (input valid, input opcode, input pixel_idx, input pixel_color,
                  output ready);
endinterface

interface lsbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [lsbe_pkg::CODE_W-1:0] spi_byte;
  logic                        frame_last;

  modport source (output valid, output spi_byte, output frame_last, input ready);
  modport sink   (input valid, input spi_byte, input frame_last, output ready);
endinterface

interface lsbe_cfg_if;
  logic                        valid;
  logic                        ready;
  logic                        index;
  logic [lsbe_pkg::CODE_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/led_strip_bit_encoder.sv]
`timescale 1ns / 1ps
// Pixel store and SPI bit encoder for an addressable LED strip. Colors live in a
// synchronous RAM of LED_COUNT words with one write port and one read port; a frame is
// read out one byte per pull beat: a leading 0x00, 24 code bytes per LED (MSB first),
// and a trailing 0x00 flagged by frame_last. After reset the block runs a clearing pass
// that writes zero to every RAM word before it takes its first input beat. A pull runs
// a RAM read, then code selection into the output register, which waits while the
// output register is held by its sink; no new input beat is taken until it is done. A
// fill-all rewrites the RAM one word per cycle, and no input beat is taken meanwhile.
// Configuration writes are taken at any time and should be made while idle.

`include "led_strip_bit_encoder_defines.svh"

module led_strip_bit_encoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  lsbe_in_if.sink       in_i,
  lsbe_out_if.source    out_o,
  lsbe_cfg_if.sink      cfg_i
);

  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_OFF,
    PH_LEAD,
    PH_DATA,
    PH_TRAIL
  } phase_e;

  state_e                        state_q;
  phase_e                        phase_q;
  logic [lsbe_pkg::ADDR_W-1:0]   sweep_q;
  logic [lsbe_pkg::COLOR_W-1:0]  fill_color_q;
  logic [lsbe_pkg::ADDR_W-1:0]   led_q;
  logic [lsbe_pkg::BIT_W-1:0]    bit_q;
  logic                          em_data_q;
  logic                          em_last_q;
  logic [lsbe_pkg::BIT_W-1:0]    em_bit_q;
  logic                          out_valid_q;
  logic [lsbe_pkg::CODE_W-1:0]   out_byte_q;
  logic                          out_last_q;
  logic [lsbe_pkg::CODE_W-1:0]   zero_code_q;
  logic [lsbe_pkg::CODE_W-1:0]   one_code_q;

  logic                          in_acc;
  logic                          cfg_acc;
  logic                          out_free;
  logic                          idx_ok;
  logic                          is_write;
  lsbe_pkg::pixel_wr_t           pix_wr;
  logic                          rd_en;
  logic [lsbe_pkg::COLOR_W-1:0]  rd_data;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign idx_ok   = {1'b0, in_i.pixel_idx} <
                    (lsbe_pkg::IDX_W + 1)'(lsbe_pkg::LED_COUNT);
  assign is_write = (in_i.opcode == lsbe_pkg::OP_WRITE) ||
                    (in_i.opcode == lsbe_pkg::OP_WRITE_SEND);
  assign rd_en    = in_acc && (in_i.opcode == lsbe_pkg::OP_PULL);

  // The sweep owns the write port; no input beat is taken while it runs.
  always_comb begin
    if (state_q == ST_FILL) begin
      pix_wr.en   = 1'b1;
      pix_wr.addr = sweep_q;
      pix_wr.data = fill_color_q;
    end else begin
      pix_wr.en   = in_acc && is_write && idx_ok;
      pix_wr.addr = in_i.pixel_idx[lsbe_pkg::ADDR_W-1:0];
      pix_wr.data = in_i.pixel_color;
    end
  end

  lsbe_pixel_store u_store (
    .clk_i     (clk_i),
    .wr_i      (pix_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (led_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      phase_q      <= PH_OFF;
      sweep_q      <= '0;
      fill_color_q <= '0;
      led_q        <= '0;
      bit_q        <= lsbe_pkg::LAST_BIT;
      em_data_q    <= 1'b0;
      em_last_q    <= 1'b0;
      em_bit_q     <= '0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_last_q   <= 1'b0;
      zero_code_q  <= lsbe_pkg::ZERO_CODE_RST;
      one_code_q   <= lsbe_pkg::ONE_CODE_RST;
    end else begin
      if (cfg_acc) begin
        case (cfg_i.index)
          lsbe_pkg::CFG_ZERO_CODE: zero_code_q <= cfg_i.data;
          lsbe_pkg::CFG_ONE_CODE:  one_code_q  <= cfg_i.data;
          default: begin
          end
        endcase
      end

      // While emitting, the emit arm below decides the next output valid.
      if (out_valid_q && out_o.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_FILL: begin
          if (sweep_q == lsbe_pkg::LED_LAST) begin
            sweep_q <= '0;
            state_q <= ST_IDLE;
          end else begin
            sweep_q <= sweep_q + 1'b1;
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            case (in_i.opcode)
              lsbe_pkg::OP_WRITE: begin
              end
              lsbe_pkg::OP_WRITE_SEND, lsbe_pkg::OP_SEND: begin
                phase_q <= PH_LEAD;
                led_q   <= '0;
                bit_q   <= lsbe_pkg::LAST_BIT;
              end
              lsbe_pkg::OP_FILL_SEND: begin
                phase_q      <= PH_LEAD;
                led_q        <= '0;
                bit_q        <= lsbe_pkg::LAST_BIT;
                fill_color_q <= in_i.pixel_color;
                state_q      <= ST_FILL;
              end
              lsbe_pkg::OP_PULL: begin
                case (phase_q)
                  PH_LEAD: begin
                    em_data_q <= 1'b0;
                    em_last_q <= 1'b0;
                    phase_q   <= PH_DATA;
                    state_q   <= ST_EMIT;
                  end
                  PH_DATA: begin
                    em_data_q <= 1'b1;
                    em_last_q <= 1'b0;
                    em_bit_q  <= bit_q;
                    state_q   <= ST_EMIT;
                    if (bit_q == '0) begin
                      bit_q <= lsbe_pkg::LAST_BIT;
                      if (led_q == lsbe_pkg::LED_LAST) begin
                        phase_q <= PH_TRAIL;
                      end else begin
                        led_q <= led_q + 1'b1;
                      end
                    end else begin
                      bit_q <= bit_q - 1'b1;
                    end
                  end
                  PH_TRAIL: begin
                    em_data_q <= 1'b0;
                    em_last_q <= 1'b1;
                    phase_q   <= PH_OFF;
                    state_q   <= ST_EMIT;
                  end
                  default: begin
                    // No frame running: the pull is dropped.
                  end
                endcase
              end
              default: begin
              end
            endcase
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= em_last_q;
            state_q     <= ST_IDLE;
            if (em_data_q) begin
              out_byte_q <= rd_data[em_bit_q] ? one_code_q : zero_code_q;
            end else begin
              out_byte_q <= lsbe_pkg::FRAME_PAD;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.spi_byte   = out_byte_q;
  assign out_o.frame_last = out_last_q;

  `LSBE_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
  `LSBE_ASSERT(a_last_ends_frame, (state_q == ST_EMIT && em_last_q) |-> (phase_q == PH_OFF))
  `LSBE_ASSERT(a_data_pos_range,
    (phase_q == PH_DATA) |-> (bit_q <= lsbe_pkg::LAST_BIT && led_q <= lsbe_pkg::LED_LAST))
  `LSBE_ASSERT_NEXT(a_pull_data_emits,
    (in_acc && in_i.opcode == lsbe_pkg::OP_PULL && phase_q == PH_DATA),
    (state_q == ST_EMIT && em_data_q && !em_last_q))

endmodule

[hdl/lsbe_pixel_store.sv]
`timescale 1ns / 1ps

module lsbe_pixel_store (
  input  logic                          clk_i,
  input  lsbe_pkg::pixel_wr_t           wr_i,
  input  logic                          rd_en_i,
  input  logic [lsbe_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic [lsbe_pkg::COLOR_W-1:0]  rd_data_o
);

  logic [lsbe_pkg::COLOR_W-1:0] mem_q [lsbe_pkg::LED_COUNT];
  logic [lsbe_pkg::COLOR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // The read register holds its word until the next enabled read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sim/lsbe_frame_checker.sv]
`timescale 1ns / 1ps

module lsbe_frame_checker
  import lsbe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lsbe_in_if          in_i,
  lsbe_out_if         out_i,
  lsbe_cfg_if         cfg_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o,
  output int unsigned beat_cnt_o,
  output int unsigned frame_cnt_o
);

  localparam int unsigned FRAME_LEN   = LED_COUNT * COLOR_W + 2;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [CODE_W-1:0] spi_byte;
    logic              frame_last;
  } spi_beat_t;

  spi_beat_t          pending_beats[$];
  logic [COLOR_W-1:0] led_colors[LED_COUNT];
  int unsigned        frame_pos;
  bit                 frame_on;
  logic [CODE_W-1:0]  zero_code;
  logic [CODE_W-1:0]  one_code;

  function automatic void report(input string msg);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= MAX_REPORTS) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endfunction

  function automatic void start_frame();
    frame_on  = 1'b1;
    frame_pos = 0;
  endfunction

  // Code bytes look at the store and the code registers as they stand when the
  // pull is taken, so writes in the middle of a frame show up in later bytes.
  function automatic void predict_pull();
    spi_beat_t          beat;
    int unsigned        k;
    logic [COLOR_W-1:0] color;
    if (!frame_on) return;
    beat.frame_last = 1'b0;
    if (frame_pos == 0) begin
      beat.spi_byte = FRAME_PAD;
      frame_pos = 1;
    end else if (frame_pos >= FRAME_LEN - 1) begin
      beat.spi_byte   = FRAME_PAD;
      beat.frame_last = 1'b1;
      frame_on  = 1'b0;
      frame_pos = 0;
    end else begin
      k = frame_pos - 1;
      color = led_colors[k / COLOR_W];
      beat.spi_byte = color[COLOR_W - 1 - (k % COLOR_W)] ? one_code : zero_code;
      frame_pos++;
    end
    pending_beats.push_back(beat);
  endfunction

  function automatic void predict_item(input logic [OP_W-1:0] op,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [COLOR_W-1:0] color);
    case (op)
      OP_WRITE, OP_WRITE_SEND: begin
        if (idx < LED_COUNT) led_colors[idx] = color;
        if (op == OP_WRITE_SEND) start_frame();
      end
      OP_FILL_SEND: begin
        foreach (led_colors[i]) led_colors[i] = color;
        start_frame();
      end
      OP_SEND: start_frame();
      OP_PULL: predict_pull();
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spi_beat_t want;
    if (!rst_ni) begin
      foreach (led_colors[i]) led_colors[i] = '0;
      frame_on  = 1'b0;
      frame_pos = 0;
      zero_code = ZERO_CODE_RST;
      one_code  = ONE_CODE_RST;
      pending_beats.delete();
    end else begin
      // The output beat always belongs to an older pull, so check it first.
      if (out_i.valid && out_i.ready) begin
        beat_cnt_o++;
        if (pending_beats.size() == 0) begin
          report($sformatf("no beat expected, got spi_byte %02h frame_last %0b",
                           out_i.spi_byte, out_i.frame_last));
        end else begin
          want = pending_beats.pop_front();
          if (out_i.spi_byte !== want.spi_byte) begin
            report($sformatf("spi_byte expected %02h got %02h",
                             want.spi_byte, out_i.spi_byte));
          end
          if (out_i.frame_last !== want.frame_last) begin
            report($sformatf("frame_last expected %0b got %0b",
                             want.frame_last, out_i.frame_last));
          end
          if (want.frame_last) frame_cnt_o++;
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_ZERO_CODE: zero_code = cfg_i.data;
          CFG_ONE_CODE:  one_code  = cfg_i.data;
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        predict_item(in_i.opcode, in_i.pixel_idx, in_i.pixel_color);
      end
    end
    pending_cnt_o = pending_beats.size();
  end

endmodule

[sim/tb_led_strip_bit_encoder.sv]
`timescale 1ns / 1ps

module tb_led_strip_bit_encoder;
  import lsbe_pkg::*;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned SETTLE_CYCLES = LED_COUNT + 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SQUEEZE_PULLS = 40;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned FRAME_LEN     = LED_COUNT * COLOR_W + 2;
  localparam int unsigned PHASE_ITEMS   = 150;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  lsbe_in_if  in_if();
  lsbe_out_if out_if();
  lsbe_cfg_if cfg_if();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned beat_cnt;
  int unsigned frame_cnt;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned item_cnt;
  int unsigned cfg_cnt;
  int unsigned cycle_cnt;
  bit          hold_req;

  always #(CLK_HALF) clk_i = ~clk_i;

  led_strip_bit_encoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  lsbe_frame_checker u_frame_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_if),
    .out_i          (out_if),
    .cfg_i          (cfg_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt),
    .beat_cnt_o     (beat_cnt),
    .frame_cnt_o    (frame_cnt)
  );

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d beats outstanding", cycle_cnt, pending_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Output side: random back-pressure, plus a long hold-off when requested.
  initial begin : spi_sink
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic logic [IDX_W-1:0] rand_index();
    if ($urandom_range(3) != 0) return IDX_W'($urandom_range(LED_COUNT - 1));
    return IDX_W'($urandom);
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] color);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.pixel_idx   <= idx;
    in_if.pixel_color <= color;
    do @(posedge clk_i); while (!in_if.ready);
    item_cnt++;
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CODE_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= sel;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    cfg_cnt++;
  endtask

  // Stops offering items and waits until every predicted beat has come out.
  task automatic drain_beats();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_item(OP_PULL, rand_index(), rand_color());
    for (int op = int'(OP_SPARE_FIRST); op <= int'(OP_SPARE_LAST); op++) begin
      send_item(OP_W'(op), rand_index(), rand_color());
    end
    send_item(OP_WRITE, 10'd0, 24'hFFFFFF);
    send_item(OP_WRITE, IDX_W'(LED_COUNT - 1), 24'h800000);
    send_item(OP_WRITE, IDX_W'(LED_COUNT), 24'hFFFFFF);
    send_item(OP_WRITE, '1, 24'hAAAAAA);
    send_item(OP_WRITE_SEND, 10'd1, 24'h000001);
    repeat (3) send_item(OP_PULL, rand_index(), rand_color());
    send_item(OP_SEND, rand_index(), rand_color());
    repeat (2) send_item(OP_PULL, rand_index(), rand_color());
    // LED 0 is cleared while its bits are being sent.
    send_item(OP_WRITE, 10'd0, 24'h000000);
    repeat (2) send_item(OP_PULL, rand_index(), rand_color());
    send_item(OP_FILL_SEND, rand_index(), 24'h5A5A5A);
    repeat (2) send_item(OP_PULL, rand_index(), rand_color());
    send_item(OP_WRITE_SEND, '1, 24'h123456);
    repeat (2) send_item(OP_PULL, rand_index(), rand_color());
    drain_beats();
  endtask

  // Mostly a frame start followed by a run of pulls with stray writes and frame restarts; the rest
  // is noise over all opcodes. Some runs are long enough to reach the frame end.
  task automatic run_random(input int unsigned budget, input bit full_first);
    int unsigned sent;
    int unsigned run_len;
    int unsigned pulls;
    int unsigned roll;
    int unsigned n;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(2))
          0: send_item(OP_WRITE_SEND, rand_index(), rand_color());
          1: send_item(OP_FILL_SEND, rand_index(), rand_color());
          default: send_item(OP_SEND, rand_index(), rand_color());
        endcase
        sent++;
        if (full_first && sent == 1) run_len = FRAME_LEN + 2;
        else if ($urandom_range(9) == 0) run_len = FRAME_LEN + $urandom_range(3);
        else run_len = $urandom_range(48, 1);
        pulls = 0;
        while (pulls < run_len) begin
          roll = $urandom_range(99);
          if (roll < 6) begin
            send_item(OP_WRITE, rand_index(), rand_color());
          end else if (roll < 8 && run_len < FRAME_LEN) begin
            send_item(OP_SEND, rand_index(), rand_color());
          end else begin
            send_item(OP_PULL, rand_index(), rand_color());
            pulls++;
          end
          sent++;
        end
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) send_item(OP_W'($urandom_range(7)), rand_index(), rand_color());
        sent += n;
      end
      if ($urandom_range(9) == 0) drain_beats();
    end
  endtask

  task automatic run_phase(input logic [CODE_W-1:0] zero_val, input logic [CODE_W-1:0] one_val,
                           input int unsigned snd_pct, input int unsigned rcv_pct,
                           input bit full_first, input bit squeeze);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    write_reg(CFG_ZERO_CODE, zero_val);
    write_reg(CFG_ONE_CODE, one_val);
    if (squeeze) begin
      // The sink stalls for a long stretch while pulls keep coming, so the
      // block backs up and has to stall its input.
      send_item(OP_SEND, rand_index(), rand_color());
      hold_req = 1'b1;
      repeat (SQUEEZE_PULLS) send_item(OP_PULL, rand_index(), rand_color());
      drain_beats();
    end
    run_random(PHASE_ITEMS, full_first);
    drain_beats();
  endtask

  initial begin : stimulus
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.opcode      = OP_WRITE;
    in_if.pixel_idx   = '0;
    in_if.pixel_color = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_ZERO_CODE;
    cfg_if.data       = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_phase(8'h00, 8'hFF, 11, 78, 1'b1, 1'b0);
    run_phase(8'hFF, 8'h00, 78, 11, 1'b0, 1'b0);
    run_phase(CODE_W'($urandom), CODE_W'($urandom), 0, 0, 1'b0, 1'b1);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d items and %0d code register writes; checked %0d SPI beats in %0d frames.",
             item_cnt, cfg_cnt, beat_cnt, frame_cnt);
    $display("Idle mixes on both sides, a long sink hold-off and full drains; %0d mismatches.",
             mismatch_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/lsbe_pkg.sv
hdl/lsbe_if.sv
hdl/lsbe_pixel_store.sv
hdl/led_strip_bit_encoder.sv
sim/lsbe_frame_checker.sv
sim/tb_led_strip_bit_encoder.sv
